### hdl/jqsr_pkg.sv
// Shared constants, codes and helpers for the jitter queue sequence ring.
`timescale 1ns / 1ps
package jqsr_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int SEQ_W     = 32;
    localparam int CFG_W     = 7;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int OUT_DATA_W = ((ADDR_W + SEQ_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_FIND  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_FULL      = 3'd1,
        STS_EMPTY     = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_ORDER     = 3'd4
    } status_t;

    // Clamp a written depth into 1..DEPTH.
    function automatic logic [CNT_W-1:0] clamp_depth(input logic [CFG_W-1:0] value);
        logic [CNT_W-1:0] result;
        if (value == '0)
        begin
            result = CNT_W'(1);
        end
        else if (32'(value) > DEPTH)
        begin
            result = CNT_W'(DEPTH);
        end
        else
        begin
            result = CNT_W'(value);
        end
        return result;
    endfunction

endpackage

### hdl/jqsr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module jqsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/jitter_queue_sequence_ring_unit.sv
// Ring queue of sequence numbers: push, pop, sorted lookup and queue clear.
// Push and clear: pointers and fill count are updated in the execute state, then the result is registered.
// Pop: one RAM read at the tail; the read data becomes the result in the pop-data state.
// Find: newest-entry check, then binary search over one or two spans, each probe a RAM read and a compare;
// each item is finished before the next is taken, once its result has moved to the output register.
// Reset (rst_n low, asynchronous) empties the queue and sets the depth in use to DEPTH.
`timescale 1ns / 1ps
module jitter_queue_sequence_ring_unit
    import jqsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: depth_in_use
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SEQ_W-1:0]      s_axis_tdata,  // [31:0] seq
    input  logic [OP_W-1:0]       s_axis_tuser,  // [1:0] op
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [5:0] slot, [37:6] seq_out, [44:38] count
    output logic [STATUS_W-1:0]   m_axis_tuser   // [2:0] status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_DATA,
        S_NEW_CMP,
        S_SRCH,
        S_SRCH_CMP,
        S_CHK_CMP,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [CNT_W-1:0]   cap_reg, cap_next;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [ADDR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [SEQ_W-1:0]   last_seq_reg, last_seq_next;
    logic               last_valid_reg, last_valid_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic               second_reg, second_next;
    status_t            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_slot_reg, res_slot_next;
    logic [SEQ_W-1:0]   res_seq_reg, res_seq_next;
    logic [CNT_W-1:0]   res_count_reg, res_count_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [ADDR_W-1:0]  out_slot_reg, out_slot_next;
    logic [SEQ_W-1:0]   out_seq_reg, out_seq_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [SEQ_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [SEQ_W-1:0]   ram_rdata;

    logic [CNT_W-1:0]   mid;
    logic [ADDR_W-1:0]  newest;
    logic               span_end;
    logic               push_order_bad;

    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] inc;
        inc = {1'b0, ptr} + CNT_W'(1);
        return (inc >= cap) ? '0 : inc[ADDR_W-1:0];
    endfunction

    jqsr_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (DEPTH)
    ) u_seq_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign newest = (head_reg == '0) ? ADDR_W'(cap_reg - CNT_W'(1)) : head_reg - ADDR_W'(1);
    assign push_order_bad = last_valid_reg &&
        ((last_seq_reg == {1'b0, {(SEQ_W-1){1'b1}}}) ||
         (seq_reg != last_seq_reg + SEQ_W'(1)));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-ADDR_W-SEQ_W-CNT_W){1'b0}},
                            out_count_reg, out_seq_reg, out_slot_reg};

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        seq_next        = seq_reg;
        cap_next        = cap_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        last_seq_next   = last_seq_reg;
        last_valid_next = last_valid_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        end_next        = end_reg;
        second_next     = second_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_seq_next    = res_seq_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_seq_next    = out_seq_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_wdata       = seq_reg;
        ram_raddr       = tail_reg;
        span_end        = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = op_t'(s_axis_tuser);
                    seq_next   = s_axis_tdata;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = STS_OK;
                res_slot_next   = '0;
                res_seq_next    = seq_reg;
                res_count_next  = fill_reg;
                state_next      = S_DONE;
                unique case (op_reg)
                    OP_PUSH:
                    begin
                        if (fill_reg >= cap_reg)
                        begin
                            res_status_next = STS_FULL;
                        end
                        else if (push_order_bad)
                        begin
                            res_status_next = STS_ORDER;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            res_slot_next   = head_reg;
                            head_next       = advance(head_reg, cap_reg);
                            fill_next       = fill_reg + CNT_W'(1);
                            res_count_next  = fill_reg + CNT_W'(1);
                            last_seq_next   = seq_reg;
                            last_valid_next = 1'b1;
                        end
                    end
                    OP_POP:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = STS_EMPTY;
                            res_seq_next    = '0;
                        end
                        else
                        begin
                            ram_raddr  = tail_reg;
                            state_next = S_POP_DATA;
                        end
                    end
                    OP_FIND:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = STS_NOT_FOUND;
                        end
                        else
                        begin
                            ram_raddr  = newest;
                            state_next = S_NEW_CMP;
                        end
                    end
                    OP_CLEAR:
                    begin
                        res_seq_next    = '0;
                        res_count_next  = '0;
                        head_next       = '0;
                        tail_next       = '0;
                        fill_next       = '0;
                        last_seq_next   = '0;
                        last_valid_next = 1'b0;
                    end
                endcase
            end
            S_POP_DATA:
            begin
                res_slot_next  = tail_reg;
                res_seq_next   = ram_rdata;
                tail_next      = advance(tail_reg, cap_reg);
                fill_next      = fill_reg - CNT_W'(1);
                res_count_next = fill_reg - CNT_W'(1);
                state_next     = S_DONE;
            end
            S_NEW_CMP:
            begin
                if (ram_rdata == seq_reg)
                begin
                    res_slot_next = newest;
                    state_next    = S_DONE;
                end
                else if (head_reg > tail_reg)
                begin
                    lo_next     = {1'b0, tail_reg};
                    hi_next     = {1'b0, head_reg};
                    end_next    = {1'b0, head_reg};
                    second_next = 1'b0;
                    state_next  = S_SRCH;
                end
                else
                begin
                    lo_next     = '0;
                    hi_next     = {1'b0, head_reg};
                    end_next    = {1'b0, head_reg};
                    second_next = 1'b1;
                    state_next  = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = mid[ADDR_W-1:0];
                    state_next = S_SRCH_CMP;
                end
                else if (lo_reg < end_reg)
                begin
                    ram_raddr  = lo_reg[ADDR_W-1:0];
                    state_next = S_CHK_CMP;
                end
                else
                begin
                    span_end = 1'b1;
                end
            end
            S_SRCH_CMP:
            begin
                // lower bound: keep the first entry not below the key
                if ($signed(ram_rdata) < $signed(seq_reg))
                begin
                    lo_next = mid + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRCH;
            end
            S_CHK_CMP:
            begin
                if (ram_rdata == seq_reg)
                begin
                    res_slot_next = lo_reg[ADDR_W-1:0];
                    state_next    = S_DONE;
                end
                else
                begin
                    span_end = 1'b1;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_seq_next    = res_seq_reg;
                    out_count_next  = res_count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // span missed: search the upper span, or give up
        if (span_end)
        begin
            if (second_reg)
            begin
                lo_next     = {1'b0, tail_reg};
                hi_next     = cap_reg;
                end_next    = cap_reg;
                second_next = 1'b0;
                state_next  = S_SRCH;
            end
            else
            begin
                res_status_next = STS_NOT_FOUND;
                res_slot_next   = '0;
                state_next      = S_DONE;
            end
        end

        // a depth write resizes and empties the queue
        if (cfg_we)
        begin
            cap_next        = clamp_depth(cfg_wdata);
            head_next       = '0;
            tail_next       = '0;
            fill_next       = '0;
            last_seq_next   = '0;
            last_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= CNT_W'(DEPTH);
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            last_seq_reg   <= '0;
            last_valid_reg <= 1'b0;
            second_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cap_reg        <= cap_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            last_seq_reg   <= last_seq_next;
            last_valid_reg <= last_valid_next;
            second_reg     <= second_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        seq_reg        <= seq_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        end_reg        <= end_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_seq_reg    <= res_seq_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_seq_reg    <= out_seq_next;
        out_count_reg  <= out_count_next;
    end

    a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap_reg)
        else $error("fill count above depth in use");

    a_ptrs_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, head_reg} < cap_reg) && ({1'b0, tail_reg} < cap_reg))
        else $error("ring pointer outside depth in use");

    a_meet_full_or_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == tail_reg) && (fill_reg != '0) |-> fill_reg == cap_reg)
        else $error("pointers meet on a partly filled ring");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while another is in work");

endmodule
